FILE: rtl/core/ave_pkg.sv
// ----------------------------------------------------------------------------
// ave_pkg: shared definitions for the altitude and vertical speed estimator
// Field widths, limits, register indexes, datapath operations and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ave_pkg;

  // payload widths
  localparam int ALT_W   = 27;
  localparam int TIME_W  = 32;
  localparam int SPD_W   = 21;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 20;

  // arithmetic widths
  localparam int SUM_W   = 36;
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int DIV_W   = 48;
  localparam int DIV_CNT_W = 6;

  // limits and scales
  localparam logic [16:0] GAIN_ONE    = 17'd65536;
  localparam logic [19:0] US_PER_S    = 20'd1000000;
  localparam int          ALT_LIMIT   = 40500000;
  localparam int          SPEED_LIMIT = 1000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALT_GAIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DT      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLES = 4'd5;

  // register reset values
  localparam logic [16:0] RST_ALT_GAIN    = 17'd32768;
  localparam logic [16:0] RST_SPEED_GAIN  = 17'd26214;
  localparam logic [19:0] RST_MIN_DT      = 20'd5000;
  localparam logic [16:0] RST_STABLE      = 17'd50;
  localparam logic [7:0]  RST_MIN_SAMPLES = 8'd50;
  localparam logic [7:0]  RST_MAX_SAMPLES = 8'd200;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_CAL   = 4'd2;
  localparam logic [OP_W-1:0] OP_CDIVS = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OP_W-1:0] OP_GRND  = 4'd5;
  localparam logic [OP_W-1:0] OP_REL   = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL1A = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL2A = 4'd8;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd9;
  localparam logic [OP_W-1:0] OP_RNDA  = 4'd10;
  localparam logic [OP_W-1:0] OP_DIFF  = 4'd11;
  localparam logic [OP_W-1:0] OP_MULV  = 4'd12;
  localparam logic [OP_W-1:0] OP_SDIVS = 4'd13;
  localparam logic [OP_W-1:0] OP_RAW   = 4'd14;
  localparam logic [OP_W-1:0] OP_MUL1S = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            mul2s;     // second speed filter product
    logic            rnds;      // round into speed filter
    logic            out_load;  // move result into output register
  } ave_cmd_t;

  typedef struct packed {
    logic tracking;
    logic first_track;
    logic cal_end;
    logic dt_ok;
    logic div_last;
    logic out_free;
  } ave_stat_t;

endpackage

FILE: rtl/core/ave_if.sv
// ----------------------------------------------------------------------------
// ave_if: stream channels of the altitude and vertical speed estimator
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface ave_in_if
  import ave_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ALT_W-1:0]  altitude_mm;
  logic [TIME_W-1:0]        time_us;
  modport source (output valid, output altitude_mm, output time_us, input ready);
  modport sink   (input valid, input altitude_mm, input time_us, output ready);
endinterface

interface ave_out_if
  import ave_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     tracking;
  logic                     calibration_done;
  logic signed [ALT_W-1:0]  ground_mm;
  logic signed [ALT_W-1:0]  relative_mm;
  logic signed [ALT_W-1:0]  smoothed_mm;
  logic signed [SPD_W-1:0]  speed_mm_s;
  modport source (output valid, output tracking, output calibration_done,
                  output ground_mm, output relative_mm, output smoothed_mm,
                  output speed_mm_s, input ready);
  modport sink   (input valid, input tracking, input calibration_done,
                  input ground_mm, input relative_mm, input smoothed_mm,
                  input speed_mm_s, output ready);
endinterface

interface ave_cfg_if
  import ave_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DAT_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ave_dpath.sv
// ----------------------------------------------------------------------------
// ave_dpath: estimator datapath
// Registers, calibration accumulator, shared multiplier, shared restoring
// divider, filters and the output register, driven by controller operations.
// ----------------------------------------------------------------------------
module ave_dpath
  import ave_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ave_cmd_t                 cmd,
  output ave_stat_t                stat,
  input  logic signed [ALT_W-1:0]  in_alt,
  input  logic [TIME_W-1:0]        in_time,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [CFG_DAT_W-1:0]     cfg_dat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_tracking,
  output logic                     out_done,
  output logic signed [ALT_W-1:0]  out_ground,
  output logic signed [ALT_W-1:0]  out_rel,
  output logic signed [ALT_W-1:0]  out_smooth,
  output logic signed [SPD_W-1:0]  out_speed
);

  // configuration
  logic [16:0] ag_r, sg_r, stable_r;
  logic [19:0] min_dt_r;
  logic [7:0]  min_s_r, max_s_r;

  // control state
  logic phase_r, first_r, done_r, trk_r, out_valid_r, neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [7:0] count_r;

  // payload state
  logic signed [ALT_W-1:0]   alt_r, prev_r, ground_r, rel_r, filt_r, lsa_r;
  logic signed [SPD_W-1:0]   fspd_r, vraw_r;
  logic [TIME_W-1:0]         time_r, last_time_r, dt_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [MUL_A_W-1:0] diff_r;
  logic signed [PROD_W-1:0]  prod_r, acc_r;
  logic [DIV_W-1:0]          num_r;
  logic [TIME_W-1:0]         den_r, rem_r;

  logic                      o_trk_r, o_done_r;
  logic signed [ALT_W-1:0]   o_gnd_r, o_rel_r, o_smo_r;
  logic signed [SPD_W-1:0]   o_spd_r;

  function automatic logic signed [ALT_W-1:0] clamp_alt(input logic signed [33:0] v);
    if (v > 34'sd40500000) clamp_alt = 27'sd40500000;
    else if (v < -34'sd40500000) clamp_alt = -27'sd40500000;
    else clamp_alt = v[ALT_W-1:0];
  endfunction

  function automatic logic signed [SPD_W-1:0] clamp_spd(input logic signed [33:0] v);
    if (v > 34'sd1000000) clamp_spd = 21'sd1000000;
    else if (v < -34'sd1000000) clamp_spd = -21'sd1000000;
    else clamp_spd = v[SPD_W-1:0];
  endfunction

  // saturated gains
  logic [16:0] ga, gs;
  assign ga = (ag_r > GAIN_ONE) ? GAIN_ONE : ag_r;
  assign gs = (sg_r > GAIN_ONE) ? GAIN_ONE : sg_r;

  // calibration step
  logic [7:0]               cnt_inc;
  logic signed [ALT_W:0]    cdiff;
  logic [ALT_W:0]           cdiff_abs;
  logic                     end_stable, cal_end;
  assign cnt_inc    = count_r + 8'd1;
  assign cdiff      = {alt_r[ALT_W-1], alt_r} - {prev_r[ALT_W-1], prev_r};
  assign cdiff_abs  = cdiff[ALT_W] ? (~cdiff + 1'b1) : cdiff;
  assign end_stable = (cnt_inc >= min_s_r) && (cdiff_abs < {11'd0, stable_r});
  assign cal_end    = end_stable || (cnt_inc >= max_s_r);

  // relative altitude and elapsed time
  logic signed [ALT_W:0] rel_raw;
  assign rel_raw = {alt_r[ALT_W-1], alt_r} - {ground_r[ALT_W-1], ground_r};

  // shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul2s) begin
      mul_a = MUL_A_W'(fspd_r);
      mul_b = MUL_B_W'(GAIN_ONE - gs);
    end else begin
      case (cmd.op)
        OP_MUL1A: begin mul_a = MUL_A_W'(rel_r);  mul_b = MUL_B_W'(ga); end
        OP_MUL2A: begin mul_a = MUL_A_W'(filt_r); mul_b = MUL_B_W'(GAIN_ONE - ga); end
        OP_MULV:  begin mul_a = diff_r;           mul_b = US_PER_S; end
        OP_MUL1S: begin mul_a = MUL_A_W'(vraw_r); mul_b = MUL_B_W'(gs); end
        default:  begin mul_a = '0;               mul_b = '0; end
      endcase
    end
  end
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // q16 rounding, ties away from zero
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [33:0]       rnd_q;
  assign rnd_sum = acc_r + (acc_r[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
  assign rnd_q   = 34'($signed(rnd_sum[PROD_W-1:16]));

  // divider step
  logic [TIME_W:0] div_sh;
  logic            div_ge;
  assign div_sh = {rem_r, num_r[DIV_W-1]};
  assign div_ge = div_sh >= {1'b0, den_r};

  // magnitudes for divider start
  logic [SUM_W-1:0]  sum_abs;
  logic [PROD_W-1:0] prod_abs;
  assign sum_abs  = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign prod_abs = prod_r[PROD_W-1] ? (~prod_r + 1'b1) : prod_r;

  // raw speed from quotient
  logic [19:0] vmag;
  assign vmag = (num_r > DIV_W'(SPEED_LIMIT)) ? US_PER_S : num_r[19:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ag_r     <= RST_ALT_GAIN;
      sg_r     <= RST_SPEED_GAIN;
      min_dt_r <= RST_MIN_DT;
      stable_r <= RST_STABLE;
      min_s_r  <= RST_MIN_SAMPLES;
      max_s_r  <= RST_MAX_SAMPLES;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ALT_GAIN:    ag_r     <= cfg_dat[16:0];
        REG_SPEED_GAIN:  sg_r     <= cfg_dat[16:0];
        REG_MIN_DT:      min_dt_r <= cfg_dat;
        REG_STABLE:      stable_r <= cfg_dat[16:0];
        REG_MIN_SAMPLES: min_s_r  <= cfg_dat[7:0];
        REG_MAX_SAMPLES: max_s_r  <= cfg_dat[7:0];
        default: ;
      endcase
    end
  end

  // estimator state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      first_r     <= 1'b1;
      done_r      <= 1'b0;
      trk_r       <= 1'b0;
      neg_r       <= 1'b0;
      count_r     <= '0;
      div_cnt_r   <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      ground_r    <= '0;
      filt_r      <= '0;
      fspd_r      <= '0;
      last_time_r <= '0;
      lsa_r       <= '0;
    end else begin
      // second speed filter product shares the product pipe
      if (cmd.mul2s) begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      if (cmd.rnds) begin
        fspd_r <= clamp_spd(rnd_q);
        lsa_r  <= filt_r;
      end
      case (cmd.op)
        OP_LOAD: begin
          alt_r  <= in_alt;
          time_r <= in_time;
          trk_r  <= phase_r;
          done_r <= 1'b0;
        end
        OP_CAL: begin
          sum_r   <= sum_r + SUM_W'(alt_r);
          count_r <= cnt_inc;
          if (!end_stable) prev_r <= alt_r;
        end
        OP_CDIVS: begin
          num_r     <= DIV_W'(sum_abs) + DIV_W'(count_r >> 1);
          den_r     <= TIME_W'(count_r);
          rem_r     <= '0;
          neg_r     <= sum_r[SUM_W-1];
          div_cnt_r <= DIV_CNT_W'(DIV_W);
        end
        OP_DIV: begin
          rem_r     <= div_ge ? TIME_W'(div_sh - {1'b0, den_r}) : div_sh[TIME_W-1:0];
          num_r     <= {num_r[DIV_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r - 1'b1;
        end
        OP_GRND: begin
          ground_r <= neg_r ? -$signed(num_r[ALT_W-1:0]) : $signed(num_r[ALT_W-1:0]);
          phase_r  <= 1'b1;
          done_r   <= 1'b1;
        end
        OP_REL: begin
          rel_r       <= clamp_alt(34'(rel_raw));
          dt_r        <= time_r - last_time_r;
          last_time_r <= time_r;
          if (first_r) begin
            filt_r  <= clamp_alt(34'(rel_raw));
            lsa_r   <= clamp_alt(34'(rel_raw));
            fspd_r  <= '0;
            first_r <= 1'b0;
          end
        end
        OP_MUL1A, OP_MULV, OP_MUL1S: prod_r <= mul_p;
        OP_MUL2A: begin
          acc_r  <= prod_r;
          prod_r <= mul_p;
        end
        OP_ADD:  acc_r  <= acc_r + prod_r;
        OP_RNDA: filt_r <= clamp_alt(rnd_q);
        OP_DIFF: diff_r <= MUL_A_W'(filt_r) - MUL_A_W'(lsa_r);
        OP_SDIVS: begin
          num_r     <= prod_abs[DIV_W-1:0] + DIV_W'(dt_r >> 1);
          den_r     <= dt_r;
          rem_r     <= '0;
          neg_r     <= prod_r[PROD_W-1];
          div_cnt_r <= DIV_CNT_W'(DIV_W);
        end
        OP_RAW: vraw_r <= neg_r ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_trk_r  <= trk_r;
      o_done_r <= done_r;
      o_gnd_r  <= ground_r;
      o_rel_r  <= trk_r ? rel_r  : '0;
      o_smo_r  <= trk_r ? filt_r : '0;
      o_spd_r  <= trk_r ? fspd_r : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tracking = o_trk_r;
  assign out_done     = o_done_r;
  assign out_ground   = o_gnd_r;
  assign out_rel      = o_rel_r;
  assign out_smooth   = o_smo_r;
  assign out_speed    = o_spd_r;

  // status to controller
  assign stat.tracking    = phase_r;
  assign stat.first_track = first_r;
  assign stat.cal_end     = cal_end;
  assign stat.dt_ok       = dt_r > TIME_W'(min_dt_r);
  assign stat.div_last    = div_cnt_r == DIV_CNT_W'(1);
  assign stat.out_free    = !out_valid_r || out_ready;

endmodule

FILE: rtl/core/ave_ctrl.sv
// ----------------------------------------------------------------------------
// ave_ctrl: estimator sequencer
// Walks each sample through calibration or tracking and issues at most one
// datapath operation per cycle, stalling at the end until the output is free.
// ----------------------------------------------------------------------------
module ave_ctrl
  import ave_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output ave_cmd_t  cmd,
  input  ave_stat_t stat
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SEL   = 5'd1;
  localparam logic [4:0] S_CAL   = 5'd2;
  localparam logic [4:0] S_CDIVS = 5'd3;
  localparam logic [4:0] S_CDIV  = 5'd4;
  localparam logic [4:0] S_GRND  = 5'd5;
  localparam logic [4:0] S_REL   = 5'd6;
  localparam logic [4:0] S_MUL1A = 5'd7;
  localparam logic [4:0] S_MUL2A = 5'd8;
  localparam logic [4:0] S_ADDA  = 5'd9;
  localparam logic [4:0] S_RNDA  = 5'd10;
  localparam logic [4:0] S_DIFF  = 5'd11;
  localparam logic [4:0] S_MULV  = 5'd12;
  localparam logic [4:0] S_SDIVS = 5'd13;
  localparam logic [4:0] S_SDIV  = 5'd14;
  localparam logic [4:0] S_RAW   = 5'd15;
  localparam logic [4:0] S_MUL1S = 5'd16;
  localparam logic [4:0] S_MUL2S = 5'd17;
  localparam logic [4:0] S_ADDS  = 5'd18;
  localparam logic [4:0] S_RNDS  = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and operation
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.mul2s    = 1'b0;
    cmd.rnds     = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SEL;
        end
      end
      S_SEL:   state_nxt = stat.tracking ? S_REL : S_CAL;
      S_CAL: begin
        cmd.op    = OP_CAL;
        state_nxt = stat.cal_end ? S_CDIVS : S_OUT;
      end
      S_CDIVS: begin cmd.op = OP_CDIVS; state_nxt = S_CDIV; end
      S_CDIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_nxt = S_GRND;
      end
      S_GRND:  begin cmd.op = OP_GRND; state_nxt = S_OUT; end
      S_REL: begin
        cmd.op    = OP_REL;
        state_nxt = stat.first_track ? S_OUT : S_MUL1A;
      end
      S_MUL1A: begin cmd.op = OP_MUL1A; state_nxt = S_MUL2A; end
      S_MUL2A: begin cmd.op = OP_MUL2A; state_nxt = S_ADDA; end
      S_ADDA:  begin cmd.op = OP_ADD;   state_nxt = S_RNDA; end
      S_RNDA: begin
        cmd.op    = OP_RNDA;
        state_nxt = stat.dt_ok ? S_DIFF : S_OUT;
      end
      S_DIFF:  begin cmd.op = OP_DIFF;  state_nxt = S_MULV; end
      S_MULV:  begin cmd.op = OP_MULV;  state_nxt = S_SDIVS; end
      S_SDIVS: begin cmd.op = OP_SDIVS; state_nxt = S_SDIV; end
      S_SDIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_nxt = S_RAW;
      end
      S_RAW:   begin cmd.op = OP_RAW;   state_nxt = S_MUL1S; end
      S_MUL1S: begin cmd.op = OP_MUL1S; state_nxt = S_MUL2S; end
      S_MUL2S: begin cmd.mul2s = 1'b1;  state_nxt = S_ADDS; end
      S_ADDS:  begin cmd.op = OP_ADD;   state_nxt = S_RNDS; end
      S_RNDS:  begin cmd.rnds = 1'b1;   state_nxt = S_OUT; end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/altitude_velocity_estimator.sv
// ----------------------------------------------------------------------------
// altitude_velocity_estimator: ground-referenced altitude and vertical speed
// Calibrates a ground level from the first samples after reset, then tracks
// filtered relative altitude and filtered vertical speed per sample.
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one beat per sample (altitude_mm, time_us); out_ch returns
//   exactly one result beat per sample, in order. cfg_ch writes one register
//   per beat (index, data) and is always ready; write only while idle.
// per-sample sequence, one sample at a time, ready to ready
//   calibration sample: load, select, accumulate, output; the sample that
//     ends calibration also runs the 48-step restoring divider for the mean
//   first tracked sample: load, select, relative altitude, output
//   tracked sample, interval not above min_dt_us: altitude filter only
//   tracked sample with speed update: altitude filter, then the same shared
//     divider forming mm/s plus two passes of the shared multiplier per filter
// reset
//   rst_n low clears calibration, filters and registers to their defaults
// stall
//   a finished result waits in the output register; the next sample is
//   taken and processed meanwhile, and holds at the end until out_ch frees
// ----------------------------------------------------------------------------
module altitude_velocity_estimator
  import ave_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  ave_in_if.sink     in_ch,
  ave_out_if.source  out_ch,
  ave_cfg_if.sink    cfg_ch
);

  ave_cmd_t  cmd;
  ave_stat_t stat;

  // registers accept every write beat
  assign cfg_ch.ready = 1'b1;

  ave_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ave_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_alt       (in_ch.altitude_mm),
    .in_time      (in_ch.time_us),
    .cfg_we       (cfg_ch.valid),
    .cfg_idx      (cfg_ch.index),
    .cfg_dat      (cfg_ch.data),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_tracking (out_ch.tracking),
    .out_done     (out_ch.calibration_done),
    .out_ground   (out_ch.ground_mm),
    .out_rel      (out_ch.relative_mm),
    .out_smooth   (out_ch.smoothed_mm),
    .out_speed    (out_ch.speed_mm_s)
  );

endmodule
